FILE: src/assert_macros.svh
// assertion macros used by the ring buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TWRB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ring buffer assertion failed");

// expression must never be true outside reset
`define TWRB_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("ring buffer forbidden condition seen");

`endif

FILE: src/twrb_pkg.sv
// types and constants of the time window ring buffer
`default_nettype none

package twrb_pkg;

  localparam int STAMP_W    = 64;
  localparam int DATA_W     = 32;
  localparam int INDEX_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AGE_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE  = 2'd2;

  localparam logic [31:0]        GAP_RESET       = 32'd3000;
  localparam logic [COUNT_W-1:0] CAP_RESET       = 11'd1024;
  localparam logic               OVERWRITE_RESET = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_EXP_RD,
    S_EXP_CHK,
    S_READ,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic push;
    logic exp_rd;
    logic exp_drop;
    logic rd_issue;
    logic load_result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic held_zero;
    logic held_le1;
    logic expired;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/twrb_if.sv
// handshake channel interfaces of the time window ring buffer
`default_nettype none

interface twrb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [twrb_pkg::STAMP_W-1:0] stamp;
  logic        [twrb_pkg::DATA_W-1:0]  data_in;
  logic        [twrb_pkg::INDEX_W-1:0] read_index;

  modport source (output valid, output opcode, output stamp, output data_in,
                  output read_index, input ready);
  modport sink   (input valid, input opcode, input stamp, input data_in,
                  input read_index, output ready);
endinterface

interface twrb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [twrb_pkg::DATA_W-1:0]   data_out;
  logic signed [twrb_pkg::STAMP_W-1:0]  stamp_out;
  logic        [twrb_pkg::COUNT_W-1:0]  entry_count;
  logic        [twrb_pkg::COUNT_W-1:0]  evicted_count;
  logic signed [twrb_pkg::STAMP_W-1:0]  latest_stamp;
  logic        [twrb_pkg::STATUS_W-1:0] status;

  modport source (output valid, output data_out, output stamp_out, output entry_count,
                  output evicted_count, output latest_stamp, output status,
                  input ready);
  modport sink   (input valid, input data_out, input stamp_out, input entry_count,
                  input evicted_count, input latest_stamp, input status,
                  output ready);
endinterface

interface twrb_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [twrb_pkg::CFG_IDX_W-1:0]        index;
  logic [twrb_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/time_window_ring_buffer.sv
// Time window ring buffer: a circular store of (timestamp, value) words.
// in_i carries one word per item: opcode push stores stamp and data_in after
// the newest entry, then drops the oldest entries while the newest stamp minus
// the oldest one exceeds the age gap; opcode read returns the entry at
// read_index counted from the oldest. Each item yields one word on out_o.
// cfg_i writes the age gap, the capacity in use (empties the store) and the
// overwrite mode, one word at a time, taken at once; write only while idle.
// Sequence: a read latches the item, reads the store at read_index if it is
// in range and loads the result register. A push latches the item, writes
// the store unless it is dropped, reads the oldest stamp and drops expired
// entries one by one, each drop fetching the next oldest stamp through the
// registered read of the single store read port, then loads the result.
// One item is in work at a time; in_i is ready again once the result sits in
// the output register.
// Reset empties the store and restores the register defaults; the stores need
// no clearing. If out_o stalls, one finished result waits in the output
// register and the next item is accepted and worked, holding before its own
// result until the register frees.
`default_nettype none

module time_window_ring_buffer #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  twrb_in_if.sink     in_i,
  twrb_out_if.source  out_o,
  twrb_cfg_if.sink    cfg_i
);

  twrb_pkg::cmd_t cmd;
  twrb_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  twrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_read_i  (in_i.opcode == twrb_pkg::OP_READ),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  twrb_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .stamp_i         (in_i.stamp),
    .data_in_i       (in_i.data_in),
    .read_index_i    (in_i.read_index),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .data_out_o      (out_o.data_out),
    .stamp_out_o     (out_o.stamp_out),
    .entry_count_o   (out_o.entry_count),
    .evicted_count_o (out_o.evicted_count),
    .latest_stamp_o  (out_o.latest_stamp),
    .status_o        (out_o.status)
  );

endmodule

`default_nettype wire

FILE: src/twrb_ctrl.sv
// sequencing state machine of the time window ring buffer
`default_nettype none

module twrb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_read_i,
  input  wire twrb_pkg::sts_t sts_i,
  output logic                in_ready_o,
  output twrb_pkg::cmd_t      cmd_o
);

  twrb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twrb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      twrb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = in_read_i ? twrb_pkg::S_READ : twrb_pkg::S_PUSH;
        end
      end
      twrb_pkg::S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = twrb_pkg::S_EXP_RD;
      end
      twrb_pkg::S_EXP_RD: begin
        if (sts_i.held_zero) begin
          state_d = twrb_pkg::S_DONE;
        end else begin
          cmd_o.exp_rd = 1'b1;
          state_d      = twrb_pkg::S_EXP_CHK;
        end
      end
      twrb_pkg::S_EXP_CHK: begin
        // each drop also fetches the next oldest stamp while entries remain
        if (sts_i.expired) begin
          cmd_o.exp_drop = 1'b1;
          state_d        = sts_i.held_le1 ? twrb_pkg::S_DONE : twrb_pkg::S_EXP_CHK;
        end else begin
          state_d = twrb_pkg::S_DONE;
        end
      end
      twrb_pkg::S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = twrb_pkg::S_DONE;
      end
      twrb_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = twrb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = twrb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/twrb_dp.sv
// datapath of the time window ring buffer: stores, pointers, config and result register
`default_nettype none
`include "assert_macros.svh"

module twrb_dp #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire twrb_pkg::cmd_t                         cmd_i,
  output twrb_pkg::sts_t                              sts_o,
  input  wire logic signed [twrb_pkg::STAMP_W-1:0]    stamp_i,
  input  wire logic        [twrb_pkg::DATA_W-1:0]     data_in_i,
  input  wire logic        [twrb_pkg::INDEX_W-1:0]    read_index_i,
  input  wire logic                                   cfg_valid_i,
  input  wire logic        [twrb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic        [twrb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                                   out_ready_i,
  output logic                                        out_valid_o,
  output logic             [twrb_pkg::DATA_W-1:0]     data_out_o,
  output logic signed      [twrb_pkg::STAMP_W-1:0]    stamp_out_o,
  output logic             [twrb_pkg::COUNT_W-1:0]    entry_count_o,
  output logic             [twrb_pkg::COUNT_W-1:0]    evicted_count_o,
  output logic signed      [twrb_pkg::STAMP_W-1:0]    latest_stamp_o,
  output logic             [twrb_pkg::STATUS_W-1:0]   status_o
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int EW      = CW + 1;
  localparam int SW      = ((AW > twrb_pkg::INDEX_W) ? AW : twrb_pkg::INDEX_W) + 1;
  localparam int RST_CAP = (int'(twrb_pkg::CAP_RESET) > DEPTH) ? DEPTH
                                                              : int'(twrb_pkg::CAP_RESET);

  function automatic logic [CW-1:0] cap_of(input logic [twrb_pkg::COUNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (v == '0) begin
      w = 32'd1;
    end else if (w > 32'(DEPTH)) begin
      w = 32'(DEPTH);
    end
    return w[CW-1:0];
  endfunction

  // configuration
  logic [31:0]                  gap_q;
  logic [twrb_pkg::COUNT_W-1:0] cap_cfg_q;
  logic                         ow_q;
  logic [CW-1:0]                cap;

  // item latch
  logic signed [twrb_pkg::STAMP_W-1:0] stamp_q;
  logic        [twrb_pkg::DATA_W-1:0]  data_q;
  logic        [twrb_pkg::INDEX_W-1:0] idx_q;

  // ring state
  logic        [AW-1:0]                 oldest_q, oldest_d, oldest_inc;
  logic        [AW-1:0]                 newest_q, newest_d, newest_inc;
  logic        [CW-1:0]                 held_q, held_d;
  logic signed [twrb_pkg::STAMP_W-1:0]  last_q, last_d;
  logic        [EW-1:0]                 evicted_q, evicted_d;
  logic        [twrb_pkg::STATUS_W-1:0] status_q, status_d;
  logic                                 read_ok_q, read_ok_d;

  // stores
  logic        [VALUE_WIDTH-1:0]        val_mem [DEPTH];
  logic signed [twrb_pkg::STAMP_W-1:0]  st_mem  [DEPTH];
  logic        [VALUE_WIDTH-1:0]        val_rdata_q;
  logic signed [twrb_pkg::STAMP_W-1:0]  st_rdata_q;
  logic                                 mem_we, mem_re;
  logic        [AW-1:0]                 rd_addr;
  logic        [VALUE_WIDTH-1:0]        mem_wdata;
  logic        [63:0]                   din_wide, dout_wide;

  logic                                 cfg_we, full, idx_ok, expired, out_busy;
  logic        [AW:0]                   oldest_sum1, newest_sum1;
  logic        [SW-1:0]                 slot_sum, slot_wrap;
  logic        [AW-1:0]                 slot;
  logic        [twrb_pkg::STAMP_W-1:0]  age;
  logic        [31:0]                   held_wide, evicted_wide;

  logic                                 out_valid_q;
  logic        [twrb_pkg::DATA_W-1:0]   data_out_q;
  logic signed [twrb_pkg::STAMP_W-1:0]  stamp_out_q;
  logic        [twrb_pkg::COUNT_W-1:0]  entry_count_q;
  logic        [twrb_pkg::COUNT_W-1:0]  evicted_count_q;
  logic signed [twrb_pkg::STAMP_W-1:0]  latest_stamp_q;
  logic        [twrb_pkg::STATUS_W-1:0] status_out_q;

  assign cfg_we = cfg_valid_i;
  assign cap    = cap_of(cap_cfg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q     <= twrb_pkg::GAP_RESET;
      cap_cfg_q <= twrb_pkg::CAP_RESET;
      ow_q      <= twrb_pkg::OVERWRITE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_i)
        twrb_pkg::REG_AGE_GAP:    gap_q     <= cfg_data_i[31:0];
        twrb_pkg::REG_CAPACITY:   cap_cfg_q <= cfg_data_i[twrb_pkg::COUNT_W-1:0];
        twrb_pkg::REG_OVERWRITE:  ow_q      <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      stamp_q <= stamp_i;
      data_q  <= data_in_i;
      idx_q   <= read_index_i;
    end
  end

  // pointer steps, wrapping at the capacity in use
  assign oldest_sum1 = {1'b0, oldest_q} + (AW+1)'(1);
  assign newest_sum1 = {1'b0, newest_q} + (AW+1)'(1);
  assign oldest_inc  = (oldest_sum1 == (AW+1)'(cap)) ? '0 : oldest_sum1[AW-1:0];
  assign newest_inc  = (newest_sum1 == (AW+1)'(cap)) ? '0 : newest_sum1[AW-1:0];

  // logical index to slot: for an in-range index the sum stays below twice the capacity
  assign slot_sum  = SW'(oldest_q) + SW'(idx_q);
  assign slot_wrap = (slot_sum >= SW'(cap)) ? (slot_sum - SW'(cap)) : slot_sum;
  assign slot      = slot_wrap[AW-1:0];

  assign full    = (held_q >= cap);
  assign idx_ok  = (32'(idx_q) < 32'(held_q));
  assign age     = last_q - st_rdata_q;
  // a newest stamp below the oldest one never expires it
  assign expired = (last_q >= st_rdata_q) && (age > {32'b0, gap_q});

  assign din_wide  = {32'b0, data_q};
  assign mem_wdata = din_wide[VALUE_WIDTH-1:0];

  always_comb begin
    oldest_d  = oldest_q;
    newest_d  = newest_q;
    held_d    = held_q;
    last_d    = last_q;
    evicted_d = evicted_q;
    status_d  = status_q;
    read_ok_d = read_ok_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rd_addr   = oldest_q;
    if (cfg_we && cfg_index_i == twrb_pkg::REG_CAPACITY) begin
      oldest_d = '0;
      newest_d = AW'(cap_of(cfg_data_i[twrb_pkg::COUNT_W-1:0]) - 1);
      held_d   = '0;
    end
    if (cmd_i.latch) begin
      evicted_d = '0;
      status_d  = twrb_pkg::STATUS_OK;
      read_ok_d = 1'b0;
    end
    if (cmd_i.push) begin
      if (full && ow_q) begin
        oldest_d  = oldest_inc;
        evicted_d = EW'(1);
      end
      if (full && !ow_q) begin
        status_d = twrb_pkg::STATUS_DROPPED;
      end else begin
        newest_d = newest_inc;
        mem_we   = 1'b1;
        if (!full) begin
          held_d = held_q + CW'(1);
        end
      end
      last_d = stamp_q;
    end
    if (cmd_i.exp_rd) begin
      mem_re  = 1'b1;
      rd_addr = oldest_q;
    end
    if (cmd_i.exp_drop) begin
      oldest_d  = oldest_inc;
      held_d    = held_q - CW'(1);
      evicted_d = evicted_q + EW'(1);
      if (held_q > CW'(1)) begin
        mem_re  = 1'b1;
        rd_addr = oldest_inc;
      end
    end
    if (cmd_i.rd_issue) begin
      if (idx_ok) begin
        mem_re    = 1'b1;
        rd_addr   = slot;
        read_ok_d = 1'b1;
      end else begin
        status_d = twrb_pkg::STATUS_BAD_INDEX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      newest_q  <= AW'(RST_CAP - 1);
      held_q    <= '0;
      last_q    <= '0;
      evicted_q <= '0;
      status_q  <= twrb_pkg::STATUS_OK;
      read_ok_q <= 1'b0;
    end else begin
      oldest_q  <= oldest_d;
      newest_q  <= newest_d;
      held_q    <= held_d;
      last_q    <= last_d;
      evicted_q <= evicted_d;
      status_q  <= status_d;
      read_ok_q <= read_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      val_mem[newest_d] <= mem_wdata;
      st_mem[newest_d]  <= stamp_q;
    end
    if (mem_re) begin
      val_rdata_q <= val_mem[rd_addr];
      st_rdata_q  <= st_mem[rd_addr];
    end
  end

  // result register parts the sequencer from the receiver
  assign out_busy     = out_valid_q && !out_ready_i;
  assign dout_wide    = 64'(val_rdata_q);
  assign held_wide    = 32'(held_q);
  assign evicted_wide = 32'(evicted_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      data_out_q      <= read_ok_q ? dout_wide[twrb_pkg::DATA_W-1:0] : '0;
      stamp_out_q     <= read_ok_q ? st_rdata_q : '0;
      entry_count_q   <= held_wide[twrb_pkg::COUNT_W-1:0];
      evicted_count_q <= evicted_wide[twrb_pkg::COUNT_W-1:0];
      latest_stamp_q  <= last_q;
      status_out_q    <= status_q;
    end
  end

  assign sts_o.held_zero = (held_q == '0);
  assign sts_o.held_le1  = (held_q <= CW'(1));
  assign sts_o.expired   = expired;
  assign sts_o.out_free  = !out_busy;

  assign out_valid_o     = out_valid_q;
  assign data_out_o      = data_out_q;
  assign stamp_out_o     = stamp_out_q;
  assign entry_count_o   = entry_count_q;
  assign evicted_count_o = evicted_count_q;
  assign latest_stamp_o  = latest_stamp_q;
  assign status_o        = status_out_q;

  `TWRB_ASSERT(a_held_within_cap, clk_i, rst_ni, held_q <= cap)
  `TWRB_ASSERT(a_oldest_within_cap, clk_i, rst_ni, (AW+1)'(oldest_q) < (AW+1)'(cap))
  `TWRB_ASSERT(a_load_only_when_free, clk_i, rst_ni, cmd_i.load_result |-> !out_busy)
  `TWRB_ASSERT(a_store_leaves_entry, clk_i, rst_ni, (cmd_i.push && (!full || ow_q)) |=> (held_q != '0))
  `TWRB_ASSERT_NEVER(a_no_drop_when_empty, clk_i, rst_ni, cmd_i.exp_drop && (held_q == '0))

endmodule

`default_nettype wire

FILE: tb/twrb_window_checker.sv
// checker for the time window ring buffer: predicts each result word and compares it
`timescale 1ns / 100ps

module twrb_window_checker (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  twrb_in_if                            in_mon_i,
  twrb_out_if                           out_mon_i,
  twrb_cfg_if                           cfg_mon_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output logic [twrb_pkg::COUNT_W-1:0]  held_o
);

  localparam int SLOTS = 1024;

  typedef struct {
    logic [twrb_pkg::DATA_W-1:0]   data;
    logic [twrb_pkg::STAMP_W-1:0]  stamp;
    logic [twrb_pkg::COUNT_W-1:0]  entries;
    logic [twrb_pkg::COUNT_W-1:0]  evicted;
    logic [twrb_pkg::STAMP_W-1:0]  latest;
    logic [twrb_pkg::STATUS_W-1:0] status;
  } reply_t;

  logic [twrb_pkg::DATA_W-1:0]  win_value [SLOTS];
  logic [twrb_pkg::STAMP_W-1:0] win_stamp [SLOTS];
  int unsigned                  oldest;
  int unsigned                  newest;
  int unsigned                  held;
  logic [twrb_pkg::STAMP_W-1:0] latest;
  logic [31:0]                  gap_reg;
  logic [twrb_pkg::COUNT_W-1:0] cap_reg;
  logic                         ovw_reg;
  reply_t                       awaited_replies [$];
  int                           bad_total = 0;

  assign fail_count_o = bad_total;

  // capacity outside 1..SLOTS is clamped
  function automatic int unsigned slots_in_use();
    if (cap_reg == 0) return 1;
    if (cap_reg > SLOTS) return SLOTS;
    return cap_reg;
  endfunction

  function automatic void empty_window();
    oldest = 0;
    newest = slots_in_use() - 1;
    held   = 0;
  endfunction

  function automatic void retire_oldest();
    if (held == 0) return;
    held--;
    oldest = (oldest + 1) % slots_in_use();
  endfunction

  // exact age, a newest stamp below the oldest never expires it
  function automatic bit too_old(logic [twrb_pkg::STAMP_W-1:0] newest_ts,
                                 logic [twrb_pkg::STAMP_W-1:0] oldest_ts);
    logic [twrb_pkg::STAMP_W-1:0] age;
    if ($signed(newest_ts) < $signed(oldest_ts)) return 1'b0;
    age = newest_ts - oldest_ts;
    return age > {32'd0, gap_reg};
  endfunction

  function automatic void apply_register(logic [twrb_pkg::CFG_IDX_W-1:0] index,
                                         logic [twrb_pkg::CFG_DATA_W-1:0] value);
    case (index)
      twrb_pkg::REG_AGE_GAP: gap_reg = value;
      twrb_pkg::REG_CAPACITY: begin
        cap_reg = value[twrb_pkg::COUNT_W-1:0];
        empty_window();
      end
      twrb_pkg::REG_OVERWRITE: ovw_reg = value[0];
      default: ;
    endcase
  endfunction

  function automatic reply_t predict_window_step(logic op,
                                                 logic [twrb_pkg::STAMP_W-1:0] ts,
                                                 logic [twrb_pkg::DATA_W-1:0] value,
                                                 logic [twrb_pkg::INDEX_W-1:0] idx);
    reply_t      r;
    int unsigned cap;
    bit          keep;
    cap       = slots_in_use();
    r.data    = '0;
    r.stamp   = '0;
    r.evicted = '0;
    r.status  = twrb_pkg::STATUS_OK;
    if (op == twrb_pkg::OP_PUSH) begin
      keep = 1'b1;
      if (held >= cap) begin
        if (ovw_reg) begin
          retire_oldest();
          r.evicted++;
        end else begin
          keep     = 1'b0;
          r.status = twrb_pkg::STATUS_DROPPED;
        end
      end
      if (keep) begin
        newest            = (newest + 1) % cap;
        win_value[newest] = value;
        win_stamp[newest] = ts;
        held++;
      end
      // a dropped push still moves the latest stamp and runs expiry
      latest = ts;
      while (held != 0 && too_old(latest, win_stamp[oldest])) begin
        retire_oldest();
        r.evicted++;
      end
    end else if (idx < held) begin
      r.data  = win_value[(oldest + idx) % cap];
      r.stamp = win_stamp[(oldest + idx) % cap];
    end else begin
      r.status = twrb_pkg::STATUS_BAD_INDEX;
    end
    r.entries = twrb_pkg::COUNT_W'(held);
    r.latest  = latest;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      bad_total++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      gap_reg = twrb_pkg::GAP_RESET;
      cap_reg = twrb_pkg::CAP_RESET;
      ovw_reg = twrb_pkg::OVERWRITE_RESET;
      latest  = '0;
      empty_window();
      awaited_replies.delete();
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready)
        apply_register(cfg_mon_i.index, cfg_mon_i.data);
      if (in_mon_i.valid && in_mon_i.ready)
        awaited_replies.push_back(predict_window_step(in_mon_i.opcode, in_mon_i.stamp,
                                                      in_mon_i.data_in,
                                                      in_mon_i.read_index));
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (awaited_replies.size() == 0) begin
          $error("result word with no prediction waiting");
          bad_total++;
        end else begin
          want = awaited_replies[0];
          awaited_replies.delete(0);
          check_field("data_out", want.data, out_mon_i.data_out);
          check_field("stamp_out", want.stamp, out_mon_i.stamp_out);
          check_field("entry_count", want.entries, out_mon_i.entry_count);
          check_field("evicted_count", want.evicted, out_mon_i.evicted_count);
          check_field("latest_stamp", want.latest, out_mon_i.latest_stamp);
          check_field("status", want.status, out_mon_i.status);
        end
      end
    end
    pending_o <= awaited_replies.size();
    held_o    <= twrb_pkg::COUNT_W'(held);
  end

endmodule

FILE: tb/time_window_ring_buffer_tb.sv
// testbench top: stimulus, flow control and verdict for the time window ring buffer
`timescale 1ns / 100ps

module time_window_ring_buffer_tb;

  localparam logic [twrb_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int BLOCK_ITEMS = 300;
  localparam int HOLD_CYCLES = 400;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  int                           tx_idle_pct = 7;
  int                           rx_idle_pct = 48;
  logic                         rx_hold     = 1'b0;
  event                         rx_hold_go;
  longint                       stamp_now   = 0;
  logic [31:0]                  gap_now     = twrb_pkg::GAP_RESET;
  int unsigned                  step_max    = 100;
  int                           fail_count;
  int                           pending;
  logic [twrb_pkg::COUNT_W-1:0] held_now;

  twrb_in_if  in_ch ();
  twrb_out_if out_ch ();
  twrb_cfg_if cfg_ch ();

  time_window_ring_buffer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  twrb_window_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .cfg_mon_i    (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .held_o       (held_now)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver stall so the block fills and backs up its input
  initial begin
    forever begin
      @(rx_hold_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(logic op, logic [twrb_pkg::STAMP_W-1:0] ts,
                           logic [twrb_pkg::DATA_W-1:0] value,
                           logic [twrb_pkg::INDEX_W-1:0] idx);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.stamp      <= ts;
    in_ch.data_in    <= value;
    in_ch.read_index <= idx;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic push_word(logic [twrb_pkg::STAMP_W-1:0] ts,
                           logic [twrb_pkg::DATA_W-1:0] value);
    send_item(twrb_pkg::OP_PUSH, ts, value, twrb_pkg::INDEX_W'($urandom));
  endtask

  task automatic read_word(logic [twrb_pkg::INDEX_W-1:0] idx);
    send_item(twrb_pkg::OP_READ, {$urandom, $urandom}, $urandom, idx);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(logic [twrb_pkg::CFG_IDX_W-1:0] index,
                           logic [twrb_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // unused upper bits carry noise, the block must ignore them
  task automatic setup_window(logic [31:0] gap, logic [twrb_pkg::COUNT_W-1:0] slots,
                              logic overwrite, int unsigned step);
    wait_drained();
    write_reg(twrb_pkg::REG_AGE_GAP, gap);
    write_reg(twrb_pkg::REG_CAPACITY, {21'($urandom), slots});
    write_reg(twrb_pkg::REG_OVERWRITE, {31'($urandom), overwrite});
    gap_now  = gap;
    step_max = step;
  endtask

  // mostly a steady clock, with some steps back, window-sized jumps and wild stamps
  function automatic logic [twrb_pkg::STAMP_W-1:0] next_stamp();
    int r;
    r = $urandom_range(99);
    if (r < 80) stamp_now += $urandom_range(step_max);
    else if (r < 88) stamp_now -= $urandom_range(2 * step_max);
    else if (r < 95) stamp_now += longint'({32'd0, gap_now}) + $urandom_range(step_max);
    else stamp_now = {$urandom, $urandom};
    return stamp_now;
  endfunction

  task automatic random_item();
    int                           r;
    int                           pick;
    logic [twrb_pkg::INDEX_W-1:0] idx;
    r = $urandom_range(99);
    if (r < 35) begin
      pick = $urandom_range(99);
      if (pick < 75 && held_now != 0)
        idx = twrb_pkg::INDEX_W'($urandom_range(32'(held_now) - 1));
      else if (pick < 90) idx = twrb_pkg::INDEX_W'(32'(held_now) + $urandom_range(3));
      else idx = twrb_pkg::INDEX_W'($urandom_range(1023));
      read_word(idx);
    end else begin
      push_word(next_stamp(), $urandom);
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= twrb_pkg::OP_PUSH;
    in_ch.stamp      <= '0;
    in_ch.data_in    <= '0;
    in_ch.read_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= twrb_pkg::REG_AGE_GAP;
    cfg_ch.data      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: extreme stamps and a newest stamp older than the oldest
    read_word(10'd0);
    push_word(64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
    push_word(64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0000);
    push_word(64'd0, 32'h5555_5555);
    read_word(10'd0);
    read_word(10'd1);
    read_word(10'h3FF);
    read_word(10'd2);

    // two slots, drop when full; a dropped push still expires old entries
    setup_window(32'd3000, 11'd2, 1'b0, 100);
    read_word(10'd0);
    push_word(64'd10, 32'hAAAA_AAAA);
    push_word(64'd11, 32'h1234_5678);
    push_word(64'd12, 32'h0BAD_F00D);
    push_word(64'd5000, 32'h0000_0001);

    setup_window(32'd3000, 11'd2, 1'b1, 100);
    push_word(64'd20, 32'd20);
    push_word(64'd21, 32'd21);
    push_word(64'd22, 32'd22);
    read_word(10'd0);
    read_word(10'd1);

    // capacity zero behaves as one slot, gap zero
    setup_window(32'd0, 11'd0, 1'b1, 2);
    push_word(64'd100, 32'hCAFE_0001);
    push_word(64'd100, 32'hCAFE_0002);
    push_word(64'd99, 32'hCAFE_0003);
    read_word(10'd0);

    // capacity above the depth is clamped, widest gap, spare index ignored
    setup_window(32'hFFFF_FFFF, 11'h7FF, 1'b1, 1000);
    write_reg(REG_SPARE, $urandom);
    push_word(64'h8000_0000_0000_0000, 32'h8000_0001);
    push_word(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFE);
    read_word(10'd0);

    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        0: setup_window(32'd3000, 11'd1024, 1'b1, 120);
        1: setup_window(32'd500, 11'd16, 1'b0, 40);
        2: setup_window(32'd0, 11'd1, 1'b1, 2);
        3: setup_window(32'hFFFF_FFFF, 11'd8, 1'b1, 1_000_000);
        4: setup_window(32'd2000, 11'd64, 1'b0, 100);
        default: setup_window(32'd100_000, 11'h7FF, 1'b1, 300);
      endcase
      tx_idle_pct = (blk < 2) ? 7 : (blk < 4) ? 48 : 0;
      rx_idle_pct = (blk < 2) ? 48 : (blk < 4) ? 7 : 0;
      stamp_now   = longint'($urandom);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if (n == BLOCK_ITEMS / 2 && (blk == 1 || blk == 4)) -> rx_hold_go;
        if (n == BLOCK_ITEMS / 2 && blk == 3) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
